// ===== design/sbfd_pkg.sv =====
package sbfd_pkg;

  localparam int ADDR_W = 5;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = 5;
  localparam int CH_W   = 11;
  localparam int ACC_W  = 18;
  localparam int RAM_DEPTH = 23;

  localparam logic [7:0]       HDR_BYTE  = 8'h0F;
  localparam logic [7:0]       END_BYTE  = 8'h00;
  localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(23);
  localparam logic [IDX_W-1:0] NUM_CH    = IDX_W'(16);
  localparam logic [IDX_W-1:0] LAST_CH   = IDX_W'(17);
  localparam logic [4:0]       CH_BITS   = 5'd11;
  localparam logic [4:0]       BYTE_BITS = 5'd8;
  localparam int FLAG_A_BIT = 7;
  localparam int FLAG_B_BIT = 6;

  typedef struct packed {
    logic start;
    logic flag_a;
    logic flag_b;
  } sbfd_start_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] rd_ptr;
  } sbfd_status_t;

endpackage

// ===== design/sbfd_byte_if.sv =====
interface sbfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/sbfd_chan_if.sv =====
interface sbfd_chan_if;
  logic        valid;
  logic        ready;
  logic [4:0]  channel_index;
  logic [10:0] channel_value;
  logic        last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input last_channel, output ready);
endinterface

// ===== design/sbfd_ram.sv =====
module sbfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 23,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sbfd_ingest.sv =====
module sbfd_ingest import sbfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  sbfd_byte_if.sink         byte_in,
  input  sbfd_status_t      status,
  output sbfd_start_t       start,
  output logic              we,
  output logic [ADDR_W-1:0] waddr,
  output logic [7:0]        wdata
);

  logic             in_frame, in_frame_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [CNT_W-1:0] count_inc;
  logic             accept;

  // Hold data bytes that would overwrite entries the unpacker has not read yet.
  assign byte_in.ready = !status.busy || !in_frame || (byte_count >= FRAME_LEN) ||
                         (byte_count < status.rd_ptr);
  assign accept    = byte_in.valid && byte_in.ready;
  assign count_inc = byte_count + CNT_W'(1);
  assign waddr     = byte_count;
  assign wdata     = byte_in.rx_byte;

  always_comb begin
    in_frame_next   = in_frame;
    byte_count_next = byte_count;
    we              = 1'b0;
    start.start     = 1'b0;
    start.flag_a    = byte_in.rx_byte[FLAG_A_BIT];
    start.flag_b    = byte_in.rx_byte[FLAG_B_BIT];
    if (accept) begin
      if (byte_in.rx_byte == HDR_BYTE) begin
        in_frame_next = 1'b1;
      end else if (in_frame) begin
        we = (byte_count < FRAME_LEN);
        if (count_inc == FRAME_LEN && byte_in.rx_byte == END_BYTE) begin
          start.start     = 1'b1;
          byte_count_next = '0;
          in_frame_next   = 1'b0;
        end else if (count_inc > FRAME_LEN) begin
          // drop an overlong frame
          byte_count_next = '0;
          in_frame_next   = 1'b0;
        end else begin
          byte_count_next = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
    end else begin
      in_frame   <= in_frame_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

// ===== design/sbfd_unpack.sv =====
module sbfd_unpack import sbfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sbfd_start_t       start,
  output sbfd_status_t      status,
  output logic              re,
  output logic [ADDR_W-1:0] raddr,
  input  logic [7:0]        rdata,
  sbfd_chan_if.source       chan_out
);

  logic              busy, busy_next;
  logic [ADDR_W-1:0] rd_ptr, rd_ptr_next;
  logic              pend, pend_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [4:0]        acc_bits, acc_bits_next;
  logic [IDX_W-1:0]  ch, ch_next;
  logic              flag_a, flag_a_next;
  logic              flag_b, flag_b_next;
  logic              out_valid, out_valid_next;
  logic [IDX_W-1:0]  out_index, out_index_next;
  logic [CH_W-1:0]   out_value, out_value_next;
  logic              out_last, out_last_next;
  logic              slot_free;

  assign slot_free     = !out_valid || chan_out.ready;
  assign status.busy   = busy;
  assign status.rd_ptr = rd_ptr;
  assign raddr         = rd_ptr;

  assign chan_out.valid         = out_valid;
  assign chan_out.channel_index = out_index;
  assign chan_out.channel_value = out_value;
  assign chan_out.last_channel  = out_last;

  always_comb begin
    busy_next      = busy;
    rd_ptr_next    = rd_ptr;
    pend_next      = pend;
    acc_next       = acc;
    acc_bits_next  = acc_bits;
    ch_next        = ch;
    flag_a_next    = flag_a;
    flag_b_next    = flag_b;
    out_valid_next = out_valid && !chan_out.ready;
    out_index_next = out_index;
    out_value_next = out_value;
    out_last_next  = out_last;
    re             = 1'b0;
    if (start.start) begin
      busy_next     = 1'b1;
      rd_ptr_next   = '0;
      pend_next     = 1'b0;
      acc_next      = '0;
      acc_bits_next = '0;
      ch_next       = '0;
      flag_a_next   = start.flag_a;
      flag_b_next   = start.flag_b;
    end else if (busy) begin
      if (pend) begin
        // merge the fetched byte above the bits already held
        acc_next      = acc | (ACC_W'(rdata) << acc_bits);
        acc_bits_next = acc_bits + BYTE_BITS;
        pend_next     = 1'b0;
      end else if (ch < NUM_CH) begin
        if (acc_bits >= CH_BITS) begin
          if (slot_free) begin
            out_valid_next = 1'b1;
            out_index_next = ch;
            out_value_next = acc[CH_W-1:0];
            out_last_next  = 1'b0;
            acc_next       = acc >> CH_W;
            acc_bits_next  = acc_bits - CH_BITS;
            ch_next        = ch + IDX_W'(1);
          end
        end else begin
          re          = 1'b1;
          rd_ptr_next = rd_ptr + ADDR_W'(1);
          pend_next   = 1'b1;
        end
      end else if (slot_free) begin
        out_valid_next = 1'b1;
        out_index_next = ch;
        out_value_next = (ch == LAST_CH) ? {flag_b, 10'b0} : {flag_a, 10'b0};
        out_last_next  = (ch == LAST_CH);
        ch_next        = ch + IDX_W'(1);
        if (ch == LAST_CH) begin
          busy_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      rd_ptr    <= '0;
      acc_bits  <= '0;
      ch        <= '0;
    end else begin
      busy      <= busy_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
      rd_ptr    <= rd_ptr_next;
      acc_bits  <= acc_bits_next;
      ch        <= ch_next;
    end
    acc       <= acc_next;
    flag_a    <= flag_a_next;
    flag_b    <= flag_b_next;
    out_index <= out_index_next;
    out_value <= out_value_next;
    out_last  <= out_last_next;
  end

endmodule

// ===== design/sbus_frame_decoder.sv =====
// Takes one byte per cycle; in data mode a byte is held while its write would land on a
// frame entry the unpacker has not yet read, so the next frame stalls behind the unpack.
// After the closing byte is accepted, the unpacker starts, fetches and merges two bytes, then
// registers the first channel item. Each memory fetch is a read, then a merge; a channel item
// needs one or two fetches before it is registered, a flag item none; a frame yields 18 items.
// Synchronous reset clears header/count state and the unpacker control state; frame memory is not cleared.
module sbus_frame_decoder import sbfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sbfd_byte_if.sink   byte_in,
  sbfd_chan_if.source chan_out
);

  sbfd_start_t       start;
  sbfd_status_t      status;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  sbfd_ingest u_ingest (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .status  (status),
    .start   (start),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata)
  );

  sbfd_ram #(
    .Width (8),
    .Depth (RAM_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  sbfd_unpack u_unpack (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .status   (status),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata),
    .chan_out (chan_out)
  );

endmodule

// ===== tb/sbfd_frame_check.sv =====
`timescale 1ns / 100ps
module sbfd_frame_check import sbfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  sbfd_byte_if byte_mon,
  sbfd_chan_if chan_mon,
  output int   mismatches,
  output int   outstanding
);

  typedef struct {
    logic [IDX_W-1:0] index;
    logic [CH_W-1:0]  value;
    logic             last;
  } channel_item_t;

  channel_item_t    expected_channels[$];
  channel_item_t    seen;
  channel_item_t    want;
  logic             in_frame;
  logic [CNT_W-1:0] byte_cnt;
  logic [7:0]       frame_buf [RAM_DEPTH];

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Track header/data mode and emit the channel items of a closed frame.
  task automatic decode_byte(input logic [7:0] b);
    logic [8*RAM_DEPTH-1:0] frame_bits;
    if (b == HDR_BYTE) begin
      in_frame = 1'b1;
    end else if (in_frame) begin
      if (byte_cnt < FRAME_LEN) frame_buf[byte_cnt] = b;
      byte_cnt = byte_cnt + CNT_W'(1);
      if (byte_cnt == FRAME_LEN && b == END_BYTE) begin
        byte_cnt = '0;
        in_frame = 1'b0;
        for (int i = 0; i < RAM_DEPTH; i++) frame_bits[8*i +: 8] = frame_buf[i];
        for (int c = 0; c < NUM_CH; c++)
          expected_channels.push_back('{index: IDX_W'(c),
                                        value: frame_bits[CH_W*c +: CH_W],
                                        last: 1'b0});
        expected_channels.push_back('{index: NUM_CH,
                                      value: {frame_buf[RAM_DEPTH-1][FLAG_A_BIT], 10'b0},
                                      last: 1'b0});
        expected_channels.push_back('{index: LAST_CH,
                                      value: {frame_buf[RAM_DEPTH-1][FLAG_B_BIT], 10'b0},
                                      last: 1'b1});
      end else if (byte_cnt > FRAME_LEN) begin
        // overrun: drop the frame
        byte_cnt = '0;
        in_frame = 1'b0;
      end
    end
  endtask

  task automatic check_channel();
    seen.index = chan_mon.channel_index;
    seen.value = chan_mon.channel_value;
    seen.last  = chan_mon.last_channel;
    if (expected_channels.size() == 0) begin
      report_mismatch($sformatf("unexpected channel item: index %0d value %0d last %0b",
                                seen.index, seen.value, seen.last));
    end else begin
      want = expected_channels.pop_front();
      if (seen.index !== want.index || seen.value !== want.value || seen.last !== want.last)
        report_mismatch($sformatf(
          "channel item: got index %0d value %0d last %0b, want index %0d value %0d last %0b",
          seen.index, seen.value, seen.last, want.index, want.value, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_frame = 1'b0;
      byte_cnt = '0;
      expected_channels.delete();
    end else begin
      if (byte_mon.valid && byte_mon.ready) decode_byte(byte_mon.rx_byte);
      if (chan_mon.valid && chan_mon.ready) check_channel();
    end
    outstanding = expected_channels.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import sbfd_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_TARGET  = 500;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   idle_cycles = 0;
  int   burst_left  = 0;
  int   bytes_sent  = 0;
  bit   hold_req    = 1'b0;
  bit   hold_done;

  sbfd_byte_if byte_ch ();
  sbfd_chan_if chan_ch ();

  sbus_frame_decoder DUT (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_ch),
    .chan_out(chan_ch)
  );

  sbfd_frame_check frame_check (
    .clk(clk),
    .rst(rst),
    .byte_mon(byte_ch),
    .chan_mon(chan_ch),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Random payload byte, never a header, biased toward the extremes.
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: b = 8'h00;
      1: b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    if (b == HDR_BYTE) b = ~HDR_BYTE;
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame(input bit mid_header, input bit bad_end);
    int         split;
    logic [7:0] b;
    split = $urandom_range(0, RAM_DEPTH - 2);
    send_byte(HDR_BYTE);
    for (int i = 0; i < RAM_DEPTH - 1; i++) begin
      if (mid_header && i == split) send_byte(HDR_BYTE);
      send_byte(data_byte());
    end
    if (bad_end) begin
      b = data_byte();
      if (b == END_BYTE) b = 8'h80;
      send_byte(b);
      // one more data byte pushes the count past the frame and drops it
      send_byte(data_byte());
    end else begin
      send_byte(END_BYTE);
    end
  endtask

  initial begin
    int n;
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_byte(8'hAA);
    send_byte(HDR_BYTE);
    for (int i = 0; i < 11; i++) send_byte(8'hFF);
    send_byte(HDR_BYTE);
    for (int i = 0; i < 11; i++) send_byte(8'h00);
    send_byte(END_BYTE);

    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent > 200) hold_req = 1'b1;
      case ($urandom_range(0, 9))
        0: send_frame(1'b0, 1'b1);
        1: send_frame(1'b1, 1'b0);
        2: begin
          // bytes in header mode are ignored
          n = $urandom_range(1, 4);
          repeat (n) send_byte(data_byte());
          bytes_sent -= n;
        end
        default: send_frame(1'b0, 1'b0);
      endcase
    end
    byte_ch.valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int   mode;
    int   mode_left;
    int   stall_left;
    logic r;
    chan_ch.ready = 1'b0;
    hold_done     = 1'b0;
    mode          = 0;
    mode_left     = 0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        // hold off long enough for the decoder to back up into its input
        chan_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        r = 1'b0;
      end else begin
        case (mode)
          0: r = 1'b1;
          1: r = 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 9) == 0) begin
              stall_left = $urandom_range(0, 7);
              r = 1'b0;
            end else begin
              r = 1'b1;
            end
          end
        endcase
      end
      chan_ch.ready <= r;
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (chan_ch.valid && chan_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
design/sbfd_pkg.sv
design/sbfd_byte_if.sv
design/sbfd_chan_if.sv
design/sbfd_ram.sv
design/sbfd_ingest.sv
design/sbfd_unpack.sv
design/sbus_frame_decoder.sv
tb/sbfd_frame_check.sv
tb/testbench.sv
